[src/jpam_pkg.sv]
// Shared types, codes and helpers for the jog pendant axis mapper.
`timescale 1ns / 1ps

package jpam_pkg;

  localparam int TIME_W  = 32;
  localparam int STICK_W = 16;
  localparam int MAG_W   = STICK_W + 1;
  localparam int BAND_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [1:0]           step_t;
  typedef logic [1:0]           axis_t;
  typedef logic [1:0]           speed_t;
  typedef logic [TIME_W-1:0]    time_t;
  typedef logic signed [STICK_W-1:0] stick_t;
  typedef logic [MAG_W-1:0]     mag_t;
  typedef logic [BAND_W-1:0]    band_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  localparam speed_t SPEED_NORMAL    = 2'd0;
  localparam speed_t SPEED_PRECISION = 2'd1;
  localparam speed_t SPEED_RAPID     = 2'd2;

  localparam cfg_idx_t CFG_STALE_TIMEOUT = 2'd0;
  localparam cfg_idx_t CFG_DEAD_BAND     = 2'd1;

  localparam time_t RST_STALE_TIMEOUT = 32'd100;
  localparam band_t RST_DEAD_BAND     = 16'd4096;

  // Captured controller sample.
  typedef struct packed {
    logic   link_up;
    time_t  sample_time;
    time_t  current_time;
    stick_t stick_left_x;
    stick_t stick_left_y;
    stick_t stick_right_y;
    logic   cycle_button;
    logic   choose_button;
    step_t  chosen_step;
    logic   cancel_button;
    logic   enable_held;
    logic [1:0] speed_buttons;
  } sample_t;

  // One command frame.
  typedef struct packed {
    logic   halt_all;
    logic   step_valid;
    step_t  step_choice;
    logic   jog_valid;
    axis_t  jog_axis;
    logic   jog_negative;
    speed_t jog_speed;
  } frame_t;

  // Magnitude of a two's complement stick value; the most negative gives 32768.
  function automatic mag_t stick_mag(input stick_t v);
    mag_t ext;
    ext = {v[STICK_W-1], v};
    return v[STICK_W-1] ? mag_t'(-ext) : ext;
  endfunction

endpackage

[src/jog_pendant_axis_mapper_top.sv]
// Jog pendant axis mapper: one controller sample in, one jog command frame out.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   in_      | in_valid / in_stall    | controller sample fields
//   out_     | out_valid / out_stall  | command frame fields
//   cfg_     | cfg_we                 | cfg_index, cfg_wdata
//
// Each transaction passes through the sample register and then the frame register;
// one transaction per cycle is sustained while out_stall is low.
// The per-sample state updates when the sample moves into the frame register.
// rst_n (synchronous) clears state and restores stale_timeout 100, dead_band 4096.
// in_stall rises only when the sample register is full and the frame register is
// held by out_stall.
`timescale 1ns / 1ps

module jog_pendant_axis_mapper_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  jpam_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_link_up,
  input  jpam_pkg::time_t     in_sample_time,
  input  jpam_pkg::time_t     in_current_time,
  input  jpam_pkg::stick_t    in_stick_left_x,
  input  jpam_pkg::stick_t    in_stick_left_y,
  input  jpam_pkg::stick_t    in_stick_right_y,
  input  logic                in_cycle_button,
  input  logic                in_choose_button,
  input  jpam_pkg::step_t     in_chosen_step,
  input  logic                in_cancel_button,
  input  logic                in_enable_held,
  input  logic [1:0]          in_speed_buttons,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_halt_all,
  output logic                out_step_valid,
  output jpam_pkg::step_t     out_step_choice,
  output logic                out_jog_valid,
  output jpam_pkg::axis_t     out_jog_axis,
  output logic                out_jog_negative,
  output jpam_pkg::speed_t    out_jog_speed
);
  import jpam_pkg::*;

  time_t   stale_timeout_r;
  band_t   dead_band_r;

  logic    s1_valid_r;
  sample_t s1_r;
  logic    out_valid_r;
  frame_t  frame_r;
  frame_t  frame_nxt;

  logic    cyc_prev_r, cyc_prev_nxt;
  logic    cho_prev_r, cho_prev_nxt;
  logic    wait_center_r, wait_center_nxt;
  logic    axis_held_r, axis_held_nxt;
  axis_t   held_axis_r, held_axis_nxt;
  step_t   next_step_r, next_step_nxt;

  logic    advance;
  logic    take_in;
  time_t   age;
  logic    stale;
  mag_t    mx, my, mz, band_ext;
  logic    centered;
  logic    cyc_rise, cho_rise;
  axis_t   axis_sel;
  mag_t    sel_mag;
  logic    sel_neg;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;

  assign age      = s1_r.current_time - s1_r.sample_time;
  assign stale    = age > stale_timeout_r;
  assign mx       = stick_mag(s1_r.stick_left_x);
  assign my       = stick_mag(s1_r.stick_left_y);
  assign mz       = stick_mag(s1_r.stick_right_y);
  assign band_ext = mag_t'(dead_band_r);
  assign centered = (mx <= band_ext) && (my <= band_ext) && (mz <= band_ext);
  assign cyc_rise = s1_r.cycle_button && !cyc_prev_r;
  assign cho_rise = s1_r.choose_button && !cho_prev_r;

  // Axis to read: the held one, or a fresh pick when nothing is locked.
  always_comb begin
    axis_sel = held_axis_r;
    if (!axis_held_r) begin
      if (mz > band_ext) begin
        axis_sel = AXIS_Z;
      end else if (mx >= my) begin
        axis_sel = AXIS_X;
      end else begin
        axis_sel = AXIS_Y;
      end
    end
  end

  always_comb begin
    case (axis_sel)
      AXIS_X: begin
        sel_mag = mx;
        sel_neg = s1_r.stick_left_x[STICK_W-1];
      end
      AXIS_Y: begin
        sel_mag = my;
        sel_neg = s1_r.stick_left_y[STICK_W-1];
      end
      default: begin
        sel_mag = mz;
        sel_neg = s1_r.stick_right_y[STICK_W-1];
      end
    endcase
  end

  always_comb begin
    frame_nxt          = '0;
    frame_nxt.halt_all = 1'b1;
    cyc_prev_nxt    = cyc_prev_r;
    cho_prev_nxt    = cho_prev_r;
    wait_center_nxt = wait_center_r;
    axis_held_nxt   = axis_held_r;
    held_axis_nxt   = held_axis_r;
    next_step_nxt   = next_step_r;
    if (!s1_r.link_up || stale) begin
      // Drop lock and history on a lost or old sample.
      axis_held_nxt   = 1'b0;
      wait_center_nxt = 1'b0;
      cyc_prev_nxt    = 1'b0;
      cho_prev_nxt    = 1'b0;
    end else begin
      cyc_prev_nxt = s1_r.cycle_button;
      cho_prev_nxt = s1_r.choose_button;
      if (s1_r.cancel_button) begin
        axis_held_nxt   = 1'b0;
        wait_center_nxt = 1'b1;
      end else if (!s1_r.enable_held) begin
        axis_held_nxt   = 1'b0;
        wait_center_nxt = 1'b0;
        if (centered && cho_rise) begin
          frame_nxt.halt_all    = 1'b0;
          frame_nxt.step_valid  = 1'b1;
          frame_nxt.step_choice = s1_r.chosen_step;
        end else if (centered && cyc_rise) begin
          frame_nxt.halt_all    = 1'b0;
          frame_nxt.step_valid  = 1'b1;
          frame_nxt.step_choice = next_step_r;
          next_step_nxt         = next_step_r + step_t'(1);
        end
      end else if (wait_center_r) begin
        if (centered) begin
          wait_center_nxt = 1'b0;
        end
      end else if (axis_held_r || !centered) begin
        held_axis_nxt = axis_sel;
        if (sel_mag <= band_ext) begin
          // Locked axis came back to center: release and wait.
          axis_held_nxt   = 1'b0;
          wait_center_nxt = 1'b1;
        end else begin
          axis_held_nxt          = 1'b1;
          frame_nxt.halt_all     = 1'b0;
          frame_nxt.jog_valid    = 1'b1;
          frame_nxt.jog_axis     = axis_sel;
          // Y and Z run inverted.
          frame_nxt.jog_negative = (axis_sel == AXIS_X) ? sel_neg : !sel_neg;
          if (s1_r.speed_buttons[1]) begin
            frame_nxt.jog_speed = SPEED_PRECISION;
          end else if (s1_r.speed_buttons[0]) begin
            frame_nxt.jog_speed = SPEED_RAPID;
          end else begin
            frame_nxt.jog_speed = SPEED_NORMAL;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_timeout_r <= RST_STALE_TIMEOUT;
      dead_band_r     <= RST_DEAD_BAND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STALE_TIMEOUT: stale_timeout_r <= cfg_wdata;
        CFG_DEAD_BAND:     dead_band_r     <= cfg_wdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      cyc_prev_r    <= 1'b0;
      cho_prev_r    <= 1'b0;
      wait_center_r <= 1'b0;
      axis_held_r   <= 1'b0;
      held_axis_r   <= AXIS_X;
      next_step_r   <= '0;
    end else begin
      if (take_in) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        cyc_prev_r    <= cyc_prev_nxt;
        cho_prev_r    <= cho_prev_nxt;
        wait_center_r <= wait_center_nxt;
        axis_held_r   <= axis_held_nxt;
        held_axis_r   <= held_axis_nxt;
        next_step_r   <= next_step_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_r <= '{link_up:       in_link_up,
                sample_time:   in_sample_time,
                current_time:  in_current_time,
                stick_left_x:  in_stick_left_x,
                stick_left_y:  in_stick_left_y,
                stick_right_y: in_stick_right_y,
                cycle_button:  in_cycle_button,
                choose_button: in_choose_button,
                chosen_step:   in_chosen_step,
                cancel_button: in_cancel_button,
                enable_held:   in_enable_held,
                speed_buttons: in_speed_buttons};
    end
    if (advance) begin
      frame_r <= frame_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_halt_all     = frame_r.halt_all;
  assign out_step_valid   = frame_r.step_valid;
  assign out_step_choice  = frame_r.step_choice;
  assign out_jog_valid    = frame_r.jog_valid;
  assign out_jog_axis     = frame_r.jog_axis;
  assign out_jog_negative = frame_r.jog_negative;
  assign out_jog_speed    = frame_r.jog_speed;

  a_frame_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({frame_r.halt_all, frame_r.step_valid, frame_r.jog_valid}))
    else $error("frame is not exactly one of halt, step, jog");

  a_lock_axis: assert property (@(posedge clk) disable iff (!rst_n)
    axis_held_r |-> (held_axis_r != 2'd3))
    else $error("locked axis code out of range");

  a_stale_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (!s1_r.link_up || stale)) |=>
      (!axis_held_r && !wait_center_r && !cyc_prev_r && !cho_prev_r))
    else $error("stale or unlinked sample left state behind");

  a_jog_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && frame_nxt.jog_valid) |=> (axis_held_r && held_axis_r == frame_r.jog_axis))
    else $error("jog frame without matching axis lock");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule
